// ===== hdl/um32_pkg.sv =====
// ----------------------------------------------------------------------------
// UM-32 execute core package
// Shared types, command codes and decode constants.
// ----------------------------------------------------------------------------
package um32_pkg;

	localparam int unsigned RegCount = 8;
	localparam int unsigned RegIdxW = 3;
	localparam int unsigned QueueDepthDefault = 2;

	localparam logic [3:0] CMD_NONE = 4'd0;
	localparam logic [3:0] CMD_LOAD = 4'd1;
	localparam logic [3:0] CMD_STORE = 4'd2;
	localparam logic [3:0] CMD_ALLOC = 4'd3;
	localparam logic [3:0] CMD_FREE = 4'd4;
	localparam logic [3:0] CMD_OUTPUT = 4'd5;
	localparam logic [3:0] CMD_INPUT = 4'd6;
	localparam logic [3:0] CMD_LOADPROG = 4'd7;
	localparam logic [3:0] CMD_HALT = 4'd8;
	localparam logic [3:0] CMD_FAULT = 4'd9;

	localparam logic [3:0] OP_CMOV = 4'd0;
	localparam logic [3:0] OP_INDEX = 4'd1;
	localparam logic [3:0] OP_AMEND = 4'd2;
	localparam logic [3:0] OP_ADD = 4'd3;
	localparam logic [3:0] OP_MUL = 4'd4;
	localparam logic [3:0] OP_DIV = 4'd5;
	localparam logic [3:0] OP_NAND = 4'd6;
	localparam logic [3:0] OP_HALT = 4'd7;
	localparam logic [3:0] OP_ALLOC = 4'd8;
	localparam logic [3:0] OP_FREE = 4'd9;
	localparam logic [3:0] OP_OUTPUT = 4'd10;
	localparam logic [3:0] OP_INPUT = 4'd11;
	localparam logic [3:0] OP_LOADPROG = 4'd12;
	localparam logic [3:0] OP_ORTHO = 4'd13;

	localparam logic [7:0] EOF_CHAR = 8'hFF;

	typedef struct packed {
		logic is_reply;
		logic [3:0] op;
		logic [RegIdxW-1:0] ra;
		logic [RegIdxW-1:0] rb;
		logic [RegIdxW-1:0] rc;
		logic [24:0] imm;
		logic [31:0] data;
	} um32_decoded_t;

	typedef enum logic [1:0] {
		EX_IDLE,
		EX_MUL,
		EX_DIV,
		EX_DONE
	} um32_ex_state_t;

	typedef struct packed {
		logic [3:0] command;
		logic [31:0] array_id;
		logic [31:0] offset;
		logic [31:0] value;
		logic [31:0] next_pc;
	} um32_result_t;

endpackage

// ===== hdl/um32_front.sv =====
// ----------------------------------------------------------------------------
// UM-32 front end
// Accepts input words, splits instruction fields and queues them.
// ----------------------------------------------------------------------------
module um32_front import um32_pkg::*; #(
	parameter int unsigned QueueDepth = QueueDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic mode,
	input logic [31:0] instruction,
	input logic [31:0] reply_data,
	input logic reply_eof,
	output logic dq_valid,
	input logic dq_take,
	output um32_decoded_t dq_item
);

	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

	um32_decoded_t mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0] cnt_q;
	um32_decoded_t dec;
	logic do_push, do_pop;

	always_comb begin
		dec.is_reply = mode;
		dec.op = instruction[31:28];
		dec.ra = (dec.op == OP_ORTHO) ? instruction[27:25] : instruction[8:6];
		dec.rb = instruction[5:3];
		dec.rc = instruction[2:0];
		dec.imm = instruction[24:0];
		dec.data = reply_eof ? {24'd0, EOF_CHAR} : reply_data;
	end

	assign full = (cnt_q == (PtrW+1)'(QueueDepth));
	assign do_push = push && !full;
	assign dq_valid = (cnt_q != '0);
	assign do_pop = dq_take && dq_valid;
	assign dq_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
		end
	end

endmodule

// ===== hdl/um32_divider.sv =====
// ----------------------------------------------------------------------------
// UM-32 divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module um32_divider import um32_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] dividend,
	input logic [31:0] divisor,
	output logic done,
	output logic [31:0] quotient
);

	logic [31:0] quo_q, dvs_q;
	logic [32:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [32:0] shifted, diff;

	assign shifted = {rem_q[31:0], quo_q[31]};
	assign diff = shifted - {1'b0, dvs_q};
	assign done = busy_q && (cnt_q == 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q && cnt_q != 6'd0) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

endmodule

// ===== hdl/um32_back.sv =====
// ----------------------------------------------------------------------------
// UM-32 back end
// Register file, program counter and execution sequencer with result queue.
// ----------------------------------------------------------------------------
module um32_back import um32_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic dq_valid,
	output logic dq_take,
	input um32_decoded_t dq_item,
	output logic empty,
	input logic pop,
	output um32_result_t res
);

	logic [31:0] regs_q [RegCount];
	logic [31:0] pc_q;
	logic [RegIdxW-1:0] pend_q;
	logic await_q, stop_q;
	um32_ex_state_t state_q, state_d;
	um32_decoded_t cur_q;
	logic [31:0] prod_q;
	logic [31:0] rb_val, rc_val, ra_val;
	logic res_valid_q;
	um32_result_t res_q, res_d;
	logic out_free, issue, div_start, div_done;
	logic [31:0] div_quo;
	logic wr_en;
	logic [RegIdxW-1:0] wr_idx;
	logic [31:0] wr_data;
	logic [31:0] pc_d;
	logic [RegIdxW-1:0] pend_d;
	logic await_d, stop_d, res_load;
	logic div_kick_q;

	assign ra_val = regs_q[dq_item.ra];
	assign rb_val = regs_q[dq_item.rb];
	assign rc_val = regs_q[dq_item.rc];
	assign out_free = !res_valid_q || pop;
	assign empty = !res_valid_q;
	assign res = res_q;

	um32_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(regs_q[cur_q.rb]), .divisor(regs_q[cur_q.rc]),
		.done(div_done), .quotient(div_quo)
	);

	always_comb begin
		state_d = state_q;
		dq_take = 1'b0;
		issue = 1'b0;
		div_start = div_kick_q;
		wr_en = 1'b0;
		wr_idx = dq_item.ra;
		wr_data = '0;
		pc_d = pc_q;
		pend_d = pend_q;
		await_d = await_q;
		stop_d = stop_q;
		res_load = 1'b0;
		res_d = '{CMD_NONE, 32'd0, 32'd0, 32'd0, pc_q};
		case (state_q)
			EX_IDLE: begin
				if (dq_valid && out_free) begin
					issue = 1'b1;
					if (stop_q) begin
						dq_take = 1'b1;
						res_load = 1'b1;
					end else if (dq_item.is_reply) begin
						dq_take = 1'b1;
						res_load = 1'b1;
						if (await_q) begin
							wr_en = 1'b1;
							wr_idx = pend_q;
							wr_data = dq_item.data;
							await_d = 1'b0;
						end
					end else if (await_q) begin
						dq_take = 1'b1;
						res_load = 1'b1;
					end else begin
						dq_take = 1'b1;
						pc_d = pc_q + 32'd1;
						res_d.next_pc = pc_q + 32'd1;
						res_load = 1'b1;
						case (dq_item.op)
							OP_CMOV: begin
								wr_en = (rc_val != 32'd0);
								wr_data = rb_val;
							end
							OP_INDEX: begin
								pend_d = dq_item.ra;
								await_d = 1'b1;
								res_d.command = CMD_LOAD;
								res_d.array_id = rb_val;
								res_d.offset = rc_val;
							end
							OP_AMEND: begin
								res_d.command = CMD_STORE;
								res_d.array_id = ra_val;
								res_d.offset = rb_val;
								res_d.value = rc_val;
							end
							OP_ADD: begin
								wr_en = 1'b1;
								wr_data = rb_val + rc_val;
							end
							OP_MUL: begin
								res_load = 1'b0;
								state_d = EX_MUL;
							end
							OP_DIV: begin
								if (rc_val == 32'd0) begin
									pc_d = pc_q;
									stop_d = 1'b1;
									res_d.command = CMD_FAULT;
									res_d.next_pc = pc_q;
								end else begin
									res_load = 1'b0;
									state_d = EX_DIV;
								end
							end
							OP_NAND: begin
								wr_en = 1'b1;
								wr_data = ~(rb_val & rc_val);
							end
							OP_HALT: begin
								pc_d = pc_q;
								stop_d = 1'b1;
								res_d.command = CMD_HALT;
								res_d.next_pc = pc_q;
							end
							OP_ALLOC: begin
								pend_d = dq_item.rb;
								await_d = 1'b1;
								res_d.command = CMD_ALLOC;
								res_d.offset = rc_val;
							end
							OP_FREE: begin
								res_d.command = CMD_FREE;
								res_d.array_id = rc_val;
							end
							OP_OUTPUT: begin
								res_d.command = CMD_OUTPUT;
								res_d.value = {24'd0, rc_val[7:0]};
							end
							OP_INPUT: begin
								pend_d = dq_item.rc;
								await_d = 1'b1;
								res_d.command = CMD_INPUT;
							end
							OP_LOADPROG: begin
								pc_d = rc_val;
								res_d.command = CMD_LOADPROG;
								res_d.array_id = rb_val;
								res_d.next_pc = rc_val;
							end
							OP_ORTHO: begin
								wr_en = 1'b1;
								wr_data = {7'd0, dq_item.imm};
							end
							default: begin
								pc_d = pc_q;
								stop_d = 1'b1;
								res_d.command = CMD_FAULT;
								res_d.next_pc = pc_q;
							end
						endcase
					end
				end
			end
			EX_MUL: begin
				wr_en = 1'b1;
				wr_idx = cur_q.ra;
				wr_data = prod_q;
				state_d = EX_DONE;
			end
			EX_DIV: begin
				if (div_done) begin
					wr_en = 1'b1;
					wr_idx = cur_q.ra;
					wr_data = div_quo;
					state_d = EX_DONE;
				end
			end
			EX_DONE: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d = EX_IDLE;
				end
			end
			default: begin
				state_d = EX_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			pc_q <= '0;
			pend_q <= '0;
			await_q <= 1'b0;
			stop_q <= 1'b0;
			res_valid_q <= 1'b0;
			div_kick_q <= 1'b0;
			for (int i = 0; i < RegCount; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			pend_q <= pend_d;
			await_q <= await_d;
			stop_q <= stop_d;
			div_kick_q <= issue && dq_take && (state_d == EX_DIV);
			if (wr_en) begin
				regs_q[wr_idx] <= wr_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue && dq_take) begin
			cur_q <= dq_item;
			prod_q <= rb_val * rc_val;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== hdl/um32_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// UM-32 instruction execute core
// Executes universal machine instructions; array store and I/O work is issued
// as command words and their replies come back as input words.
//
// Input channel: push/full queue. Each word is an instruction (mode 0) or a
// reply (mode 1). Result channel: empty/pop queue, one result word per input.
// The front end queues QueueDepth (default two) decoded words, so input is
// taken while the back end works or while a result waits to be popped.
// Most operators load the result directly; multiply adds a registered
// product and EX_MUL, divide adds EX_DIV with a one-bit-per-cycle divider,
// and both end in EX_DONE. A halt or fault stops the machine; later words
// produce empty results. Reset clears registers, program counter and queues.
// If the receiver stalls, the result register holds and the back end waits.
// ----------------------------------------------------------------------------
module um32_instruction_execute import um32_pkg::*; #(
	parameter int unsigned QueueDepth = QueueDepthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic mode,
	input logic [31:0] instruction,
	input logic [31:0] reply_data,
	input logic reply_eof,
	output logic empty,
	input logic pop,
	output logic [3:0] command,
	output logic [31:0] array_id,
	output logic [31:0] offset,
	output logic [31:0] value,
	output logic [31:0] next_pc
);

	logic dq_valid, dq_take;
	um32_decoded_t dq_item;
	um32_result_t res;

	um32_front #(.QueueDepth(QueueDepth)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .mode(mode),
		.instruction(instruction), .reply_data(reply_data),
		.reply_eof(reply_eof), .dq_valid(dq_valid), .dq_take(dq_take),
		.dq_item(dq_item)
	);

	um32_back u_back (
		.clk(clk), .arst_n(arst_n), .dq_valid(dq_valid), .dq_take(dq_take),
		.dq_item(dq_item), .empty(empty), .pop(pop), .res(res)
	);

	assign command = res.command;
	assign array_id = res.array_id;
	assign offset = res.offset;
	assign value = res.value;
	assign next_pc = res.next_pc;

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (command <= CMD_FAULT)) else $error("command out of range");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(next_pc) && $stable(command)))
		else $error("result changed while stalled");
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && command == CMD_HALT) |-> (array_id == 32'd0))
		else $error("halt carries array");

endmodule
